// ===== src/bqd_pkg.sv =====
// Shared constants and control types for the biquad filter.
package bqd_pkg;

	localparam int DEF_SAMPLE_WIDTH = 16;
	localparam int DEF_COEF_WIDTH   = 18;
	localparam int STATE_WIDTH      = 32;
	localparam int COEF_INT_BITS    = 4;
	localparam int CFG_IDX_WIDTH    = 3;

	typedef enum logic [1:0] {
		BASE_ZERO,
		BASE_D1,
		BASE_D2,
		BASE_ACC
	} bqd_base_t;

	typedef enum logic [2:0] {
		DST_NONE,
		DST_Y,
		DST_ACC,
		DST_D1,
		DST_D2
	} bqd_dst_t;

	typedef struct packed {
		logic      mul_en;
		logic      mul_y;
		bqd_base_t base_sel;
		logic      subtract;
		bqd_dst_t  dst;
	} bqd_ctrl_t;

endpackage

// ===== src/bqd_datapath.sv =====
// Shared multiplier, rounding, accumulator and delay state of the biquad filter.
module bqd_datapath
	import bqd_pkg::*;
#(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
	parameter int COEF_WIDTH   = DEF_COEF_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bqd_ctrl_t                      ctrl,
	input  logic                           load_x,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic                           clear,
	input  logic signed [COEF_WIDTH-1:0]   coef,
	output logic signed [SAMPLE_WIDTH-1:0] y
);

	localparam int CF    = COEF_WIDTH - COEF_INT_BITS;
	localparam int PW    = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int RP_W  = PW - CF;
	localparam int ACC_W = ((RP_W > STATE_WIDTH) ? RP_W : STATE_WIDTH) + 2;

	localparam logic signed [PW-1:0] HALF =
		{{(PW - CF){1'b0}}, 1'b1, {(CF - 1){1'b0}}};
	localparam logic signed [ACC_W-1:0] ST_MAX =
		{{(ACC_W - STATE_WIDTH + 1){1'b0}}, {(STATE_WIDTH - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ST_MIN =
		{{(ACC_W - STATE_WIDTH + 1){1'b1}}, {(STATE_WIDTH - 1){1'b0}}};
	localparam logic signed [ACC_W-1:0] SMP_MAX =
		{{(ACC_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SMP_MIN =
		{{(ACC_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [SAMPLE_WIDTH-1:0] y_q;
	logic signed [SAMPLE_WIDTH-1:0] mul_b;
	logic signed [PW-1:0]           prod_s1;
	logic signed [PW-1:0]           rnd;
	logic signed [RP_W-1:0]         rp;
	logic signed [ACC_W-1:0]        rp_ext;
	logic signed [ACC_W-1:0]        base;
	logic signed [ACC_W-1:0]        sum;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [STATE_WIDTH-1:0]  d1_q;
	logic signed [STATE_WIDTH-1:0]  d2_q;
	logic signed [STATE_WIDTH-1:0]  sum_sat32;
	logic signed [SAMPLE_WIDTH-1:0] sum_satsmp;

	assign mul_b = ctrl.mul_y ? y_q : x_q;

	// Round half up: add half an LSB of the sample scale, then drop the extra fraction bits.
	assign rnd    = prod_s1 + HALF;
	assign rp     = rnd[PW-1:CF];
	assign rp_ext = {{(ACC_W - RP_W){rp[RP_W-1]}}, rp};

	always_comb begin
		case (ctrl.base_sel)
			BASE_D1:  base = {{(ACC_W - STATE_WIDTH){d1_q[STATE_WIDTH-1]}}, d1_q};
			BASE_D2:  base = {{(ACC_W - STATE_WIDTH){d2_q[STATE_WIDTH-1]}}, d2_q};
			BASE_ACC: base = acc_q;
			default:  base = '0;
		endcase
	end

	assign sum = ctrl.subtract ? (base - rp_ext) : (base + rp_ext);

	always_comb begin
		if (sum > ST_MAX) begin
			sum_sat32 = ST_MAX[STATE_WIDTH-1:0];
		end else if (sum < ST_MIN) begin
			sum_sat32 = ST_MIN[STATE_WIDTH-1:0];
		end else begin
			sum_sat32 = sum[STATE_WIDTH-1:0];
		end
		if (sum > SMP_MAX) begin
			sum_satsmp = SMP_MAX[SAMPLE_WIDTH-1:0];
		end else if (sum < SMP_MIN) begin
			sum_satsmp = SMP_MIN[SAMPLE_WIDTH-1:0];
		end else begin
			sum_satsmp = sum[SAMPLE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load_x) begin
			x_q <= sample_in;
		end
		if (ctrl.mul_en) begin
			prod_s1 <= coef * mul_b;
		end
		if (ctrl.dst == DST_ACC) begin
			acc_q <= sum;
		end
		if (ctrl.dst == DST_Y) begin
			y_q <= sum_satsmp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else if (clear) begin
			d1_q <= '0;
			d2_q <= '0;
		end else begin
			if (ctrl.dst == DST_D1) begin
				d1_q <= sum_sat32;
			end
			if (ctrl.dst == DST_D2) begin
				d2_q <= sum_sat32;
			end
		end
	end

	assign y = y_q;

endmodule

// ===== src/biquad_iir_filter.sv =====
// Biquad IIR filter, transposed direct form II, on one shared multiplier.
//
//   channel  signals                                  direction  moves
//   input    in_valid, in_ready, sample_in            in         one sample word
//   output   out_valid, out_ready, sample_out         out        one filtered word
//   config   cfg_we, cfg_index, cfg_data              in         one coefficient
//
// An accepted word takes one multiplier pass per coefficient (five in all),
// each followed by one rounding add in the accumulator, overlapped one step
// deep, and then a done state that hands the result over to the output
// register; the sequencer then returns to idle to take the next word.
// The input is not ready while a word is in the sequencer; the output register
// lets a new word be accepted while the previous result still waits.
// If the output register is still full when a result finishes, the sequencer
// holds that result until the output side takes the old one.
// Reset loads b0 = 1.0 and all other coefficients as zero, and clears both
// delay registers; a coefficient write also clears both delays.
module biquad_iir_filter
	import bqd_pkg::*;
#(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
	parameter int COEF_WIDTH   = DEF_COEF_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	input  logic                           cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0]       cfg_index,
	input  logic [COEF_WIDTH-1:0]          cfg_data
);

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_WIDTH-1:0] REG_B0 = CFG_IDX_WIDTH'(0);
	localparam logic [CFG_IDX_WIDTH-1:0] REG_B1 = CFG_IDX_WIDTH'(1);
	localparam logic [CFG_IDX_WIDTH-1:0] REG_B2 = CFG_IDX_WIDTH'(2);
	localparam logic [CFG_IDX_WIDTH-1:0] REG_A1 = CFG_IDX_WIDTH'(3);
	localparam logic [CFG_IDX_WIDTH-1:0] REG_A2 = CFG_IDX_WIDTH'(4);

	// Unity gain in the coefficient format (four integer bits).
	localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
		{{(COEF_INT_BITS - 1){1'b0}}, 1'b1, {(COEF_WIDTH - COEF_INT_BITS){1'b0}}};

	// Each multiplying state names the product that is launched into the multiplier in it;
	// the accumulator consumes the product launched one state earlier.
	typedef enum logic [2:0] {
		S_IDLE,
		S_MB0,
		S_MB1,
		S_MA1,
		S_MB2,
		S_MA2,
		S_LAST,
		S_DONE
	} state_t;

	state_t                          state_q;
	logic signed [COEF_WIDTH-1:0]    b0_q, b1_q, b2_q, a1_q, a2_q;
	logic signed [COEF_WIDTH-1:0]    coef;
	logic signed [SAMPLE_WIDTH-1:0]  y;
	logic signed [SAMPLE_WIDTH-1:0]  out_q;
	logic                            out_valid_q;
	logic                            coef_write;
	logic                            accept;
	logic                            out_free;
	bqd_ctrl_t                       ctrl;

	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

	// Coefficient registers; an index beyond the list is ignored.
	always_comb begin
		coef_write = 1'b0;
		unique case (cfg_index)
			REG_B0, REG_B1, REG_B2, REG_A1, REG_A2: coef_write = cfg_we;
			default:                                coef_write = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= COEF_ONE;
			b1_q <= '0;
			b2_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_B0:  b0_q <= cfg_data;
				REG_B1:  b1_q <= cfg_data;
				REG_B2:  b2_q <= cfg_data;
				REG_A1:  a1_q <= cfg_data;
				REG_A2:  a2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Step decode. The sequence is:
	//   y  = sat_sample(rnd(b0*x) + d1)
	//   d1 = sat32(rnd(b1*x) + d2 - rnd(a1*y))
	//   d2 = sat32(rnd(b2*x) - rnd(a2*y))
	// with d2 read for the new d1 before d2 is overwritten.
	always_comb begin
		ctrl          = '0;
		ctrl.base_sel = BASE_ZERO;
		ctrl.dst      = DST_NONE;
		coef          = b0_q;
		unique case (state_q)
			S_MB0: begin
				ctrl.mul_en = 1'b1;
				coef        = b0_q;
			end
			S_MB1: begin
				ctrl.mul_en   = 1'b1;
				coef          = b1_q;
				ctrl.base_sel = BASE_D1;
				ctrl.dst      = DST_Y;
			end
			S_MA1: begin
				ctrl.mul_en   = 1'b1;
				ctrl.mul_y    = 1'b1;
				coef          = a1_q;
				ctrl.base_sel = BASE_D2;
				ctrl.dst      = DST_ACC;
			end
			S_MB2: begin
				ctrl.mul_en   = 1'b1;
				coef          = b2_q;
				ctrl.base_sel = BASE_ACC;
				ctrl.subtract = 1'b1;
				ctrl.dst      = DST_D1;
			end
			S_MA2: begin
				ctrl.mul_en   = 1'b1;
				ctrl.mul_y    = 1'b1;
				coef          = a2_q;
				ctrl.base_sel = BASE_ZERO;
				ctrl.dst      = DST_ACC;
			end
			S_LAST: begin
				ctrl.base_sel = BASE_ACC;
				ctrl.subtract = 1'b1;
				ctrl.dst      = DST_D2;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MB0;
					end
				end
				S_MB0:  state_q <= S_MB1;
				S_MB1:  state_q <= S_MA1;
				S_MA1:  state_q <= S_MB2;
				S_MB2:  state_q <= S_MA2;
				S_MA2:  state_q <= S_LAST;
				S_LAST: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The output word itself needs no reset.
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_q <= y;
		end
	end

	bqd_datapath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEF_WIDTH   (COEF_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.load_x    (accept),
		.sample_in (sample_in),
		.clear     (coef_write),
		.coef      (coef),
		.y         (y)
	);

endmodule

// ===== src/bqd_checker.sv =====
// Port-level checks of the biquad filter and their binding to the top level.
module bqd_checker
	import bqd_pkg::*;
#(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [SAMPLE_WIDTH-1:0] sample_out
);

	// A result word holds until the output side takes it.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out))
		else $error("output word changed or dropped while stalled");

	// Accepting a word makes the input busy at once.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input still ready right after accepting a word");

	// The sequencer is still at work at the later point that this property checks after accepting a word.
	a_busy_length: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##5 !in_ready)
		else $error("input ready again before the word was processed");

	// A new result appears only as the sequencer leaves its busy period.
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result offered without a word in process");

endmodule

bind biquad_iir_filter bqd_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bqd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.sample_out (sample_out)
);
